// ===== rtl/rmpf_pkg.sv =====
// Package: sizes, codes, command/status bundles and color widening for the mono page framebuffer.
`default_nettype none
package rmpf_pkg;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int PANEL_PAGES  = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_PAGES;
	localparam int ADDR_W       = $clog2(STORE_BYTES);

	localparam int X_W       = 8;
	localparam int Y_W       = 7;
	localparam int COL_W     = 7;
	localparam int PAGE_W    = 3;
	localparam int COLOR_W   = 16;
	localparam int ACT_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int LUMA_W    = 15;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_READY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LUMA_THRESHOLD = 1'd1;
	localparam logic [7:0]           LUMA_THRESHOLD_RST = 8'd20;

	// v*255/31 and v*255/63 as reciprocal multiplies (exact over the input range)
	localparam logic [21:0] W5_MUL = 22'd2156535; // 255 * ceil(2^18/31)
	localparam logic [22:0] W6_MUL = 23'd4244475; // 255 * ceil(2^20/63)

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef struct packed {
		logic in_ready;
		logic fetch;
		logic mem_we;
		logic load_out;
		logic clr_wr;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic is_clear;
		logic write_ok;
		logic read_ok;
		logic out_free;
		logic clr_last;
	} sts_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [26:0] p;
		p = 27'(v) * 27'(W5_MUL);
		return p[25:18];
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [28:0] p;
		p = 29'(v) * 29'(W6_MUL);
		return p[27:20];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rmpf_ifs.sv =====
// Interfaces: request channel, result channel and register write channel.
`default_nettype none
interface rmpf_in_if import rmpf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [X_W-1:0]    pixel_x;
	logic [Y_W-1:0]    pixel_y;
	logic [COLOR_W-1:0] color;
	logic [COL_W-1:0]  read_column;
	logic [PAGE_W-1:0] read_page;
	logic              last_in_push;

	modport source(output valid, action, pixel_x, pixel_y, color, read_column, read_page,
		last_in_push, input ready);
	modport sink(input valid, action, pixel_x, pixel_y, color, read_column, read_page,
		last_in_push, output ready);
endinterface

interface rmpf_out_if import rmpf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] page_byte;
	logic [COL_W-1:0]  byte_column;
	logic [PAGE_W-1:0] byte_page;
	logic              last_byte;

	modport source(output valid, page_byte, byte_column, byte_page, last_byte, input ready);
	modport sink(input valid, page_byte, byte_column, byte_page, last_byte, output ready);
endinterface

interface rmpf_cfg_if import rmpf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rmpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rmpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/rmpf_ctrl.sv =====
// Controller: sequences clear sweep, request capture, fetch and apply.
`default_nettype none
module rmpf_ctrl import rmpf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_APPLY = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = sts.is_clear ? ST_CLEAR : ST_APPLY;
			end
			ST_APPLY: begin
				cmd.mem_we   = sts.write_ok;
				cmd.load_out = sts.read_ok && sts.out_free;
				// hold while a read result cannot enter the output register
				if (!(sts.read_ok && !sts.out_free)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/rmpf_dp.sv =====
// Datapath: registers, request latch, luma test, page store and output register.
`default_nettype none
module rmpf_dp import rmpf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	output sts_t       sts,
	rmpf_in_if.sink    in_ch,
	rmpf_out_if.source out_ch,
	rmpf_cfg_if.sink   cfg
);

	logic              panel_ready_q;
	logic [7:0]        thr_q;

	logic [ACT_W-1:0]  act_q;
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [COLOR_W-1:0] color_q;
	logic [COL_W-1:0]  col_q;
	logic [PAGE_W-1:0] page_q;
	logic              last_q;

	logic [7:0]        r8_s1, g8_s1, b8_s1;

	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [COL_W-1:0]  out_col_q;
	logic [PAGE_W-1:0] out_page_q;
	logic              out_last_q;

	logic              wr_in_range, rd_in_range, lit;
	logic [ADDR_W-1:0] wr_addr, rd_addr, ram_raddr, ram_waddr;
	logic [BYTE_W-1:0] ram_rdata, ram_wdata, bit_mask;
	logic [LUMA_W-1:0] luma_sum, luma_bar;
	logic              ram_we;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_ready_q <= 1'b0;
			thr_q         <= LUMA_THRESHOLD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PANEL_READY:    panel_ready_q <= cfg.data[0];
				CFG_LUMA_THRESHOLD: thr_q         <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (in_ch.valid && cmd.in_ready) begin
			act_q   <= in_ch.action;
			x_q     <= in_ch.pixel_x;
			y_q     <= in_ch.pixel_y;
			color_q <= in_ch.color;
			col_q   <= in_ch.read_column;
			page_q  <= in_ch.read_page;
			last_q  <= in_ch.last_in_push;
		end
		if (cmd.fetch) begin
			r8_s1 <= widen5(color_q[15:11]);
			g8_s1 <= widen6(color_q[10:5]);
			b8_s1 <= widen5(color_q[4:0]);
		end
	end

	assign wr_in_range = (32'(x_q) < PANEL_WIDTH) && (32'(y_q) < PANEL_HEIGHT);
	assign rd_in_range = (32'(col_q) < PANEL_WIDTH) && (32'(page_q) < PANEL_PAGES);
	assign wr_addr = ADDR_W'(32'(y_q >> 3) * PANEL_WIDTH + 32'(x_q));
	assign rd_addr = ADDR_W'(32'(page_q) * PANEL_WIDTH + 32'(col_q));
	assign ram_raddr = (act_q == ACT_READ) ? rd_addr : wr_addr;

	// floor(sum/100) > thr  <=>  sum >= 100*(thr+1)
	assign luma_sum = LUMA_W'(LUMA_W'(30) * LUMA_W'(r8_s1) + LUMA_W'(59) * LUMA_W'(g8_s1)
		+ LUMA_W'(11) * LUMA_W'(b8_s1));
	assign luma_bar = LUMA_W'(LUMA_W'(100) * (LUMA_W'(thr_q) + LUMA_W'(1)));
	assign lit      = luma_sum >= luma_bar;
	assign bit_mask = BYTE_W'(1) << y_q[2:0];

	assign ram_we    = cmd.mem_we || cmd.clr_wr;
	assign ram_waddr = cmd.clr_wr ? clr_q : wr_addr;
	assign ram_wdata = cmd.clr_wr ? '0 :
		(lit ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));

	rmpf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= sts.clr_last ? '0 : clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_byte_q <= rd_in_range ? ram_rdata : '0;
			out_col_q  <= col_q;
			out_page_q <= page_q;
			out_last_q <= last_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.page_byte   = out_byte_q;
	assign out_ch.byte_column = out_col_q;
	assign out_ch.byte_page   = out_page_q;
	assign out_ch.last_byte   = out_last_q;

	always_comb begin
		sts.in_valid = in_ch.valid;
		sts.is_clear = act_q == ACT_CLEAR;
		sts.write_ok = (act_q == ACT_WRITE) && wr_in_range;
		sts.read_ok  = (act_q == ACT_READ) && panel_ready_q;
		sts.out_free = !out_valid_q || out_ch.ready;
		sts.clr_last = 32'(clr_q) == STORE_BYTES - 1;
	end

endmodule
`default_nettype wire

// ===== rtl/rgb565_mono_page_framebuffer_top.sv =====
// Top level: monochrome page-packed framebuffer with RGB565 luma-threshold pixel writes.
//
// Channels (valid/ready, a request moves when both are high):
//   in_ch  - requests: pixel write (action 0), page byte read (1), store clear (2).
//            Code 3 and off-panel writes are taken and dropped.
//   out_ch - read results: page byte plus echoed column, page and last flag.
//            Nothing comes out while panel_ready is 0.
//   cfg    - register writes, always ready: index 0 panel_ready, 1 luma_threshold.
// Timing:
//   A write or read passes through accept, store fetch and apply; the store's
//   single registered read port sets this read-modify-write loop. A read result
//   enters the output register from apply, once that register is free.
//   A clear zeroes all 1024 store bytes, one store byte per cycle.
// Reset:
//   arst_n drops the registers to panel_ready 0, threshold 20, then the
//   controller sweeps all 1024 store bytes to zero before in_ch goes ready.
// Stall:
//   One output register; the block keeps taking requests while a result waits.
//   A read meeting a full, stalled output register holds until it drains.
`default_nettype none
module rgb565_mono_page_framebuffer_top import rmpf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rmpf_in_if.sink    in_ch,
	rmpf_out_if.source out_ch,
	rmpf_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: decides what the datapath does each cycle
	rmpf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	// store, luma test, registers and output register
	rmpf_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg   (cfg)
	);

	// no request is taken while the store is being swept
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !in_ch.ready)
		else $error("request accepted during clear sweep");

	// pixel update and clear sweep never share the write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mem_we && cmd.clr_wr))
		else $error("store write port contention");

	// a result only enters a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_ch.valid || out_ch.ready))
		else $error("output register overwritten");

	// one request in flight at a time
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second request taken while busy");

endmodule
`default_nettype wire

// ===== dv/tb_rgb565_mono_page_framebuffer_top.sv =====
// Testbench: random and directed pixel writes, page reads and clears against a predicted store.
module tb_rgb565_mono_page_framebuffer_top import rmpf_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Unused action code: taken by the block and dropped
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// Hard stop. A slow correct run is roughly 850 requests with sender gaps and
	// receiver stalls, about five clears, ten idle waits and the sweep after reset,
	// which stays well under this limit.
	localparam int unsigned CYCLE_LIMIT = 600000;
	// A clear gives no result while it runs, so a quiet output does not mean idle.
	localparam int unsigned SETTLE_CYCLES = 1100;
	// Long receiver hold-off: enough to fill the output register and stall in_ch.
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned PHASE_ITEMS = 94;

	typedef struct {
		logic [ACT_W-1:0]   action;
		logic [X_W-1:0]     px;
		logic [Y_W-1:0]     py;
		logic [COLOR_W-1:0] color;
		logic [COL_W-1:0]   col;
		logic [PAGE_W-1:0]  page;
		logic               last;
	} fb_req_t;

	typedef struct {
		logic [BYTE_W-1:0] pixels;
		logic [COL_W-1:0]  col;
		logic [PAGE_W-1:0] page;
		logic              last;
	} page_byte_t;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	// Shadow of the framebuffer and its registers; holds the page bytes still owed.
	class fb_tracker;
		logic [BYTE_W-1:0] store [STORE_BYTES];
		bit                reads_on;
		logic [7:0]        threshold;
		page_byte_t        owed_bytes[$];
		int unsigned       mismatches;

		function new();
			wipe();
			reads_on   = 1'b0;
			threshold  = LUMA_THRESHOLD_RST;
			mismatches = 0;
		endfunction

		function void wipe();
			foreach (store[i]) store[i] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_PANEL_READY:    reads_on = val[0];
				CFG_LUMA_THRESHOLD: threshold = val;
				default: ;
			endcase
		endfunction

		// Widen 565 to 888 by floor division, then weighted luma against the threshold
		function bit is_lit(logic [COLOR_W-1:0] c);
			int unsigned r8, g8, b8, luma;
			r8   = int'(c[15:11]) * 255 / 31;
			g8   = int'(c[10:5]) * 255 / 63;
			b8   = int'(c[4:0]) * 255 / 31;
			luma = (30 * r8 + 59 * g8 + 11 * b8) / 100;
			return luma > int'(threshold);
		endfunction

		function void apply_request(fb_req_t r);
			int unsigned at;
			page_byte_t  e;
			case (r.action)
				ACT_WRITE: begin
					if (int'(r.px) < PANEL_WIDTH && int'(r.py) < PANEL_HEIGHT) begin
						at = int'(r.py >> 3) * PANEL_WIDTH + int'(r.px);
						store[at][r.py[2:0]] = is_lit(r.color);
					end
				end
				ACT_READ: begin
					if (reads_on) begin
						e.pixels = '0;
						if (int'(r.col) < PANEL_WIDTH && int'(r.page) < PANEL_PAGES)
							e.pixels = store[int'(r.page) * PANEL_WIDTH + int'(r.col)];
						e.col  = r.col;
						e.page = r.page;
						e.last = r.last;
						owed_bytes.push_back(e);
					end
				end
				ACT_CLEAR: wipe();
				default: ;
			endcase
		endfunction

		function void take_byte(page_byte_t got);
			page_byte_t e;
			if (owed_bytes.size() == 0) begin
				$display("%0t: unexpected page byte %02h col %0d page %0d last %0b", $time,
					got.pixels, got.col, got.page, got.last);
				mismatches++;
				return;
			end
			e = owed_bytes.pop_front();
			if (got.pixels !== e.pixels) begin
				$display("%0t: page_byte expected %02h actual %02h", $time, e.pixels, got.pixels);
				mismatches++;
			end
			if (got.col !== e.col) begin
				$display("%0t: byte_column expected %0d actual %0d", $time, e.col, got.col);
				mismatches++;
			end
			if (got.page !== e.page) begin
				$display("%0t: byte_page expected %0d actual %0d", $time, e.page, got.page);
				mismatches++;
			end
			if (got.last !== e.last) begin
				$display("%0t: last_byte expected %0b actual %0b", $time, e.last, got.last);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return owed_bytes.size();
		endfunction

		function void flush_leftovers();
			foreach (owed_bytes[i])
				$display("%0t: page byte never returned: expected %02h col %0d page %0d",
					$time, owed_bytes[i].pixels, owed_bytes[i].col, owed_bytes[i].page);
			mismatches += owed_bytes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rmpf_in_if  in_ch();
	rmpf_out_if out_ch();
	rmpf_cfg_if cfg();

	rgb565_mono_page_framebuffer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	fb_tracker tracker;

	// Sender burst state: a burst of requests, then an idle gap; steady phases never idle
	int unsigned burst_left = 0;
	bit          steady = 1'b0;

	// Receiver state; main asks for a long hold-off by bumping hold_asks
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned stall_count = 0;
	rx_mode_t    rx_mode = RX_OPEN;

	int unsigned cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stall modes that change at random intervals, plus the long
	// hold-off. Modes: always ready, mostly ready, mostly stalled, and a fixed beat.
	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left   = LONG_HOLD;
		end
		if (stall_count == 0) begin
			rx_mode     = rx_mode_t'($urandom_range(0, 3));
			stall_count = $urandom_range(16, 80);
		end else begin
			stall_count--;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:  out_ch.ready <= 1'b1;
				RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: out_ch.ready <= ($urandom_range(0, 9) < 4);
				default:  out_ch.ready <= stall_count[2];
			endcase
		end
	end

	// Result monitor: every accepted page byte goes against the oldest one owed
	always @(posedge clk) begin
		page_byte_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.pixels = out_ch.page_byte;
			got.col    = out_ch.byte_column;
			got.page   = out_ch.byte_page;
			got.last   = out_ch.last_byte;
			tracker.take_byte(got);
		end
	end

	// Random content everywhere, so fields an action does not use still toggle
	function automatic fb_req_t make_noise();
		fb_req_t r;
		r.action = ACT_W'($urandom_range(0, 3));
		r.px     = X_W'($urandom);
		r.py     = Y_W'($urandom);
		r.color  = COLOR_W'($urandom);
		r.col    = COL_W'($urandom);
		r.page   = PAGE_W'($urandom);
		r.last   = 1'($urandom);
		return r;
	endfunction

	function automatic fb_req_t make_write(int unsigned x, int unsigned y,
		logic [COLOR_W-1:0] c);
		fb_req_t r;
		r        = make_noise();
		r.action = ACT_WRITE;
		r.px     = X_W'(x);
		r.py     = Y_W'(y);
		r.color  = c;
		return r;
	endfunction

	function automatic fb_req_t make_read(int unsigned col, int unsigned page, bit last);
		fb_req_t r;
		r        = make_noise();
		r.action = ACT_READ;
		r.col    = COL_W'(col);
		r.page   = PAGE_W'(page);
		r.last   = last;
		return r;
	endfunction

	function automatic fb_req_t make_clear();
		fb_req_t r;
		r        = make_noise();
		r.action = ACT_CLEAR;
		return r;
	endfunction

	// Half fully random, half grays whose luma sweeps across any threshold
	function automatic logic [COLOR_W-1:0] pick_color();
		logic [4:0] v;
		logic [5:0] g;
		if ($urandom_range(0, 1) == 0)
			return COLOR_W'($urandom);
		v = 5'($urandom);
		g = {v, 1'($urandom)};
		return {v, g, v};
	endfunction

	// Offer one request and hold it until taken; then run the burst/gap pattern.
	// Must be entered right after a rising edge.
	task automatic push_req(input fb_req_t r);
		int unsigned gap;
		in_ch.valid        <= 1'b1;
		in_ch.action       <= r.action;
		in_ch.pixel_x      <= r.px;
		in_ch.pixel_y      <= r.py;
		in_ch.color        <= r.color;
		in_ch.read_column  <= r.col;
		in_ch.read_page    <= r.page;
		in_ch.last_in_push <= r.last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		tracker.apply_request(r);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap        = steady ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Both registers in one go; valid stays up across the pair
	task automatic configure(input bit ready_val, input logic [7:0] thr);
		cfg.valid <= 1'b1;
		cfg.index <= CFG_PANEL_READY;
		cfg.data  <= CFG_DATA_W'(ready_val);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		tracker.set_reg(CFG_PANEL_READY, CFG_DATA_W'(ready_val));
		cfg.index <= CFG_LUMA_THRESHOLD;
		cfg.data  <= thr;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		tracker.set_reg(CFG_LUMA_THRESHOLD, thr);
		cfg.valid <= 1'b0;
	endtask

	// Stop sending, collect every owed byte, then let a possible clear run out
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Consecutive columns of one page with last on the final byte; one in eight is
	// broken, with the last flag scattered at random.
	task automatic region_transfer(input int unsigned start, input int unsigned page,
		output int unsigned len);
		bit broken;
		len    = $urandom_range(1, 16);
		broken = ($urandom_range(0, 7) == 0);
		for (int unsigned k = 0; k < len; k++)
			push_req(make_read(start + k, page,
				broken ? bit'($urandom_range(0, 1)) : (k == len - 1)));
	endtask

	initial begin
		fb_req_t     r;
		int unsigned win_col, win_page, sent, pick, len, page;
		bit          ready_val;
		logic [7:0]  thr;

		tracker = new();

		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.action       = ACT_WRITE;
		in_ch.pixel_x      = '0;
		in_ch.pixel_y      = '0;
		in_ch.color        = '0;
		in_ch.read_column  = '0;
		in_ch.read_page    = '0;
		in_ch.last_in_push = 1'b0;
		out_ch.ready       = 1'b0;
		cfg.valid          = 1'b0;
		cfg.index          = CFG_PANEL_READY;
		cfg.data           = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset registers first: panel not ready, threshold 20.
		// A read now gives nothing; the write lands anyway; the unused code is dropped.
		push_req(make_read(0, 0, 1'b1));
		push_req(make_write(0, 0, 16'hFFFF));
		r        = make_noise();
		r.action = ACT_UNUSED;
		push_req(r);
		settle();

		// Threshold at its floor: anything with nonzero luma lights
		configure(1'b1, 8'd0);
		push_req(make_write(127, 63, 16'hFFFF));   // bottom-right corner
		push_req(make_write(127, 0, 16'h0001));    // faint blue: luma 0, stays dark
		push_req(make_write(0, 63, 16'h0020));     // faint green: luma 2, lit
		push_req(make_write(128, 5, 16'hFFFF));    // column just off panel
		push_req(make_write(255, 127, 16'hFFFF));  // both coordinates at their max
		push_req(make_write(5, 64, 16'hFFFF));     // row just off panel
		push_req(make_write(0, 7, 16'hFFFF));      // bottom bit of page 0
		push_req(make_read(0, 0, 1'b0));
		push_req(make_read(127, 7, 1'b1));
		push_req(make_read(0, 7, 1'b0));
		push_req(make_read(127, 0, 1'b1));
		push_req(make_read(5, 0, 1'b0));
		push_req(make_write(0, 0, 16'h0000));      // black clears a lit pixel
		push_req(make_read(0, 0, 1'b1));
		push_req(make_clear());
		push_req(make_read(0, 7, 1'b1));           // must read back zero
		push_req(make_write(64, 32, 16'hF800));    // pure red
		push_req(make_read(64, 4, 1'b1));
		settle();

		// Random phases, each with its own register setting and a 16x8 pixel window
		// that most writes and reads aim at, so reads find lit bits.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin ready_val = 1'b1; thr = 8'd20;  end
				1: begin ready_val = 1'b1; thr = 8'd0;   end
				2: begin ready_val = 1'b1; thr = 8'd255; end
				3: begin ready_val = 1'b0; thr = 8'd90;  end
				5: begin ready_val = 1'b1; thr = 8'd128; end
				7: begin ready_val = 1'b1; thr = 8'd254; end
				default: begin ready_val = 1'b1; thr = 8'($urandom_range(1, 254)); end
			endcase
			configure(ready_val, thr);
			steady   = (ph % 3 == 1);
			win_col  = $urandom_range(0, 112);
			win_page = $urandom_range(0, 7);

			// Back-pressure: receiver holds off while reads keep coming back to back
			if (ph == 1) begin
				hold_asks++;
				repeat (40)
					push_req(make_read(win_col + $urandom_range(0, 15), win_page, 1'b0));
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					push_req(make_write(win_col + $urandom_range(0, 15),
						win_page * 8 + $urandom_range(0, 7), pick_color()));
					sent++;
				end else if (pick < 55) begin
					// anywhere, mostly off panel
					push_req(make_write($urandom_range(0, 255), $urandom_range(0, 127),
						pick_color()));
					sent++;
				end else if (pick < 88) begin
					page = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : win_page;
					region_transfer(win_col + $urandom_range(0, 15), page, len);
					sent += len;
				end else if (pick < 93) begin
					push_req(make_read($urandom_range(0, 127), $urandom_range(0, 7),
						bit'($urandom_range(0, 1))));
					sent++;
				end else if (pick < 96) begin
					// ignored by the block; not counted
					r        = make_noise();
					r.action = ACT_UNUSED;
					push_req(r);
				end else if (pick < 98) begin
					push_req(make_clear());
					sent++;
				end else begin
					push_req(make_write(win_col + $urandom_range(0, 15),
						win_page * 8 + $urandom_range(0, 7), 16'h0000));
					sent++;
				end
			end
			settle();
		end

		tracker.flush_leftovers();
		if (tracker.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rmpf_pkg.sv
rtl/rmpf_ifs.sv
rtl/rmpf_ram.sv
rtl/rmpf_ctrl.sv
rtl/rmpf_dp.sv
rtl/rgb565_mono_page_framebuffer_top.sv
dv/tb_rgb565_mono_page_framebuffer_top.sv
